@@ src/ict_pkg.sv @@
// ----------------------------------------------------------------------------
// ict_pkg
// Shared types for the interval coalescing table: cell opcodes, per-cell
// status flags and the chain-wide merge decision.
// ----------------------------------------------------------------------------
package ict_pkg;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_CMP  = 2'd1,
        CELL_UPD  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    // Status one cell shows to its neighbors and to the chain control.
    typedef struct packed {
        logic valid;
        logic below;    // interval ends more than one below the value
        logic touch;    // interval overlaps or abuts the value
    } ict_flags_t;

    // Decision taken over the whole chain for one add.
    typedef struct packed {
        logic notouch;  // no interval touches: insert a new one
        logic merge2;   // two intervals touch: bridge them
        logic full;     // last cell occupied
    } ict_glob_t;

endpackage

@@ src/ict_cell.sv @@
// ----------------------------------------------------------------------------
// ict_cell
// One slot of the interval chain: holds one interval, compares it against
// the broadcast value and takes data from itself, a neighbor or the value.
// ----------------------------------------------------------------------------
module ict_cell
    import ict_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_op_t              op,
    input  ict_glob_t             glob,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [VALUE_BITS-1:0] left_start,
    input  logic [VALUE_BITS-1:0] left_end,
    input  ict_flags_t            left_flags,
    input  logic [VALUE_BITS-1:0] right_start,
    input  logic [VALUE_BITS-1:0] right_end,
    input  ict_flags_t            right_flags,
    input  logic [VALUE_BITS-1:0] wrap_start,
    input  logic [VALUE_BITS-1:0] wrap_end,
    output logic [VALUE_BITS-1:0] start_q,
    output logic [VALUE_BITS-1:0] end_q,
    output ict_flags_t            flags
);

    logic [VALUE_BITS-1:0] start_reg, start_next;
    logic [VALUE_BITS-1:0] end_reg, end_next;
    logic                  valid_reg, valid_next;
    logic                  below_reg, below_next;
    logic                  touch_reg, touch_next;

    logic [VALUE_BITS:0] end_plus1;
    logic [VALUE_BITS:0] value_plus1;
    logic                cmp_below;
    logic                cmp_touch;

    // One extra bit so that +1 never wraps.
    assign end_plus1   = {1'b0, end_reg} + {{VALUE_BITS{1'b0}}, 1'b1};
    assign value_plus1 = {1'b0, value} + {{VALUE_BITS{1'b0}}, 1'b1};
    assign cmp_below   = valid_reg && (end_plus1 < {1'b0, value});
    assign cmp_touch   = valid_reg && !cmp_below && ({1'b0, start_reg} <= value_plus1);

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        valid_next = valid_reg;
        below_next = below_reg;
        touch_next = touch_reg;
        case (op)
            CELL_CMP:
            begin
                below_next = cmp_below;
                touch_next = cmp_touch;
            end
            CELL_UPD:
            begin
                if (glob.notouch)
                begin
                    // insert: open a slot at the first cell not below the value
                    if (!glob.full && !below_reg)
                    begin
                        if (left_flags.below)
                        begin
                            start_next = value;
                            end_next   = value;
                            valid_next = 1'b1;
                        end
                        else
                        begin
                            start_next = left_start;
                            end_next   = left_end;
                            valid_next = left_flags.valid;
                        end
                    end
                end
                else if (glob.merge2)
                begin
                    if (touch_reg && right_flags.touch)
                    begin
                        end_next = right_end;
                    end
                    else if ((touch_reg && left_flags.touch) || (!below_reg && !touch_reg))
                    begin
                        // close the gap left by the absorbed interval
                        start_next = right_start;
                        end_next   = right_end;
                        valid_next = right_flags.valid;
                    end
                end
                else if (touch_reg)
                begin
                    if (value < start_reg)
                        start_next = value;
                    if (value > end_reg)
                        end_next = value;
                end
            end
            CELL_ROT:
            begin
                // rotate the occupied prefix left by one
                if (valid_reg)
                begin
                    if (right_flags.valid)
                    begin
                        start_next = right_start;
                        end_next   = right_end;
                    end
                    else
                    begin
                        start_next = wrap_start;
                        end_next   = wrap_end;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            below_reg <= 1'b0;
            touch_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            below_reg <= below_next;
            touch_reg <= touch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
    end

    assign start_q     = start_reg;
    assign end_q       = end_reg;
    assign flags.valid = valid_reg;
    assign flags.below = below_reg;
    assign flags.touch = touch_reg;

endmodule

@@ src/interval_coalescing_table.sv @@
// ----------------------------------------------------------------------------
// interval_coalescing_table
// Sorted set of disjoint closed intervals built from added values.
// ----------------------------------------------------------------------------
// The table is a row of MAX_RANGES cells, one interval per cell, kept in
// ascending order in the occupied prefix. An add beat has three steps:
// accept, a parallel compare in every cell, then one update in which every
// cell takes its own, its neighbor's or the new data (insert shifts right,
// bridging two intervals shifts left). Its single result is loaded into the
// output register at the update. A read beat is accepted, then emits one
// stored interval per cycle unless stalled, from the head cell while the
// occupied prefix rotates left; after the last beat the order is restored.
// An empty read gives one beat. The output register frees the chain as soon
// as a beat is loaded, stalling only while a result waits to be taken.
// ----------------------------------------------------------------------------
module interval_coalescing_table
    import ict_pkg::*;
#(
    parameter int MAX_RANGES = 32,
    parameter int VALUE_BITS = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [30:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] range_start,
    output logic [30:0] range_end,
    output logic        is_last,
    output logic        is_empty,
    output logic        overflow
);

    localparam int CNT_BITS = $clog2(MAX_RANGES + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_RD   = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] item_value_reg;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   rem_reg, rem_next;

    logic        out_valid_reg, out_valid_next;
    logic [30:0] out_start_reg, out_start_next;
    logic [30:0] out_end_reg, out_end_next;
    logic        out_last_reg, out_last_next;
    logic        out_empty_reg, out_empty_next;
    logic        out_ovf_reg, out_ovf_next;

    logic                  slot_free;
    logic                  accept;
    cell_op_t              op;
    ict_glob_t             glob;
    logic [VALUE_BITS+30:0] value_wide;
    logic [VALUE_BITS+30:0] head_start_wide;
    logic [VALUE_BITS+30:0] head_end_wide;

    logic [VALUE_BITS-1:0] cell_start [MAX_RANGES];
    logic [VALUE_BITS-1:0] cell_end   [MAX_RANGES];
    ict_flags_t            cell_flags [MAX_RANGES];
    logic [MAX_RANGES-1:0] touch_vec;
    logic [MAX_RANGES-2:0] pair_vec;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;

    // mask the input value to the table width
    assign value_wide = {{VALUE_BITS{1'b0}}, value};

    always_comb
    begin
        for (int i = 0; i < MAX_RANGES; i++)
            touch_vec[i] = cell_flags[i].touch;
        for (int i = 0; i < MAX_RANGES - 1; i++)
            pair_vec[i] = cell_flags[i].touch && cell_flags[i+1].touch;
    end

    assign glob.notouch = ~|touch_vec;
    assign glob.merge2  = |pair_vec;
    assign glob.full    = cell_flags[MAX_RANGES-1].valid;

    always_comb
    begin
        case (state_reg)
            S_CMP:   op = CELL_CMP;
            S_UPD:   op = slot_free ? CELL_UPD : CELL_HOLD;
            S_RD:    op = (slot_free && (count_reg != '0)) ? CELL_ROT : CELL_HOLD;
            default: op = CELL_HOLD;
        endcase
    end

    for (genvar g = 0; g < MAX_RANGES; g++)
    begin : g_cell
        logic [VALUE_BITS-1:0] l_start, l_end, r_start, r_end;
        ict_flags_t            l_flags, r_flags;

        if (g == 0)
        begin : g_left_edge
            assign l_start = '0;
            assign l_end   = '0;
            assign l_flags = '{valid: 1'b0, below: 1'b1, touch: 1'b0};
        end
        else
        begin : g_left
            assign l_start = cell_start[g-1];
            assign l_end   = cell_end[g-1];
            assign l_flags = cell_flags[g-1];
        end

        if (g == MAX_RANGES - 1)
        begin : g_right_edge
            assign r_start = '0;
            assign r_end   = '0;
            assign r_flags = '0;
        end
        else
        begin : g_right
            assign r_start = cell_start[g+1];
            assign r_end   = cell_end[g+1];
            assign r_flags = cell_flags[g+1];
        end

        ict_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .glob        (glob),
            .value       (item_value_reg),
            .left_start  (l_start),
            .left_end    (l_end),
            .left_flags  (l_flags),
            .right_start (r_start),
            .right_end   (r_end),
            .right_flags (r_flags),
            .wrap_start  (cell_start[0]),
            .wrap_end    (cell_end[0]),
            .start_q     (cell_start[g]),
            .end_q       (cell_end[g]),
            .flags       (cell_flags[g])
        );
    end

    assign head_start_wide = {31'd0, cell_start[0]};
    assign head_end_wide   = {31'd0, cell_end[0]};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rem_next   = count_reg;
                    state_next = cmd ? S_RD : S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_start_next = '0;
                    out_end_next   = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b0;
                    out_ovf_next   = glob.notouch && glob.full;
                    if (glob.notouch && !glob.full)
                        count_next = count_reg + 1'b1;
                    else if (glob.merge2)
                        count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_ovf_next   = 1'b0;
                    if (count_reg == '0)
                    begin
                        out_start_next = '0;
                        out_end_next   = '0;
                        out_last_next  = 1'b1;
                        out_empty_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        // emit the head, then advance the rotation
                        out_start_next = head_start_wide[30:0];
                        out_end_next   = head_end_wide[30:0];
                        out_empty_next = 1'b0;
                        out_last_next  = (rem_reg == CNT_BITS'(1));
                        rem_next       = rem_reg - 1'b1;
                        if (rem_reg == CNT_BITS'(1))
                            state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_value_reg <= value_wide[VALUE_BITS-1:0];
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign range_start = out_start_reg;
    assign range_end   = out_end_reg;
    assign is_last     = out_last_reg;
    assign is_empty    = out_empty_reg;
    assign overflow    = out_ovf_reg;

endmodule
